/* src/eru_pkg.sv */
// Package for the ultrasonic echo ranger: phase codes, status codes,
// register map, distance scaling constants and shared struct types.
// No dependencies.
package eru_pkg;

    // Default build values
    localparam int CLOCKS_PER_US_DEF = 40;
    localparam int WIDTH_BITS_DEF    = 24;

    // Field widths
    localparam int TRIG_W = 16;
    localparam int WAIT_W = 24;
    localparam int LATE_W = 16;
    localparam int PC_W   = 24;
    localparam int DIST_W = 17;
    localparam int REM_W  = 12;

    // Measurement phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_TRIG = 3'd1;
    localparam logic [2:0] PH_WAIT = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_MEAS = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_BADCH   = 2'd2;

    // Channel that has no sensor
    localparam logic [1:0] CH_INVALID = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_TRIG = 2'd0;
    localparam logic [1:0] REG_WAIT = 2'd1;
    localparam logic [1:0] REG_LATE = 2'd2;

    // Register reset values
    localparam logic [TRIG_W-1:0] TRIG_RST = 16'd400;
    localparam logic [WAIT_W-1:0] WAIT_RST = 24'd100000;
    localparam logic [LATE_W-1:0] LATE_RST = 16'd4000;

    // Microseconds to millimeters: mm = us * 759 / 4000
    localparam logic [REM_W:0]    MM_NUM   = 13'd759;
    localparam logic [REM_W:0]    MM_DEN   = 13'd4000;
    localparam logic [DIST_W-1:0] DIST_MAX = 17'd131071;

    typedef struct packed {
        logic [TRIG_W-1:0] trigger_clocks;
        logic [WAIT_W-1:0] echo_wait_limit;
        logic [LATE_W-1:0] late_start_clocks;
    } t_cfg;

    // Commands to the echo width counter
    typedef struct packed {
        logic clear;     // restart from zero
        logic load_one;  // restart with the current tick counted
        logic tick;      // count one more high clock
    } t_cnt_ctl;

    typedef struct packed {
        logic              busy_res;
        logic [DIST_W-1:0] distance_mm;
        logic [1:0]        status;
        logic              done_res;
        logic [2:0]        trigger_lines;
    } t_result;

endpackage

/* src/ultrasonic_echo_ranger.sv */
// Top level of the ultrasonic echo ranger: config registers, sequencer,
// echo width counter and the result register. Depends on eru_pkg.
//
// Each input beat is one sample tick (start request, channel, echo lines)
// and yields exactly one result beat (trigger lines, done, status, distance,
// busy). One beat is accepted every clock while the result side takes
// results; the result register lets a new beat in on the same clock that the
// previous result is taken, and a result that waits holds the input off. The
// result of a beat is registered on the clock that accepts it. The
// distance is kept current while the echo is high (microsecond count and
// scaled remainder), so the falling echo tick reports it with no final
// division step. No clearing pass follows reset.
module ultrasonic_echo_ranger
    import eru_pkg::*;
#(
    parameter int CLOCKS_PER_US = CLOCKS_PER_US_DEF,
    parameter int WIDTH_BITS    = WIDTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input beat
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] start_req, [2:1] channel, [5:3] echo_lines
    // Result beat
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [2:0] trigger_lines, [3] done_res, [5:4] status,
                                     // [22:6] distance_mm, [23] busy_res
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg              w_cfg;
    t_cnt_ctl          w_cnt_ctl;
    t_result           w_result;
    t_result           r_result;
    logic              r_valid;
    logic              w_accept;
    logic [DIST_W-1:0] w_mm;

    assign o_s_tready = !r_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    eru_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    eru_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_accept),
        .i_cfg        (w_cfg),
        .i_start_req  (i_s_tdata[0]),
        .i_channel    (i_s_tdata[2:1]),
        .i_echo_lines (i_s_tdata[5:3]),
        .i_mm         (w_mm),
        .o_cnt_ctl    (w_cnt_ctl),
        .o_result     (w_result)
    );

    eru_width_cnt #(
        .CLOCKS_PER_US (CLOCKS_PER_US),
        .WIDTH_BITS    (WIDTH_BITS)
    ) u_width_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_accept),
        .i_ctl   (w_cnt_ctl),
        .o_mm    (w_mm)
    );

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_result.busy_res, r_result.distance_mm, r_result.status,
                         r_result.done_res, r_result.trigger_lines};

    // A finished measurement leaves the block idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_result.done_res |-> !r_result.busy_res)
        else $error("done result with busy set");

    // Status and distance only carry meaning with done
    a_quiet_when_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_result.done_res |->
            (r_result.status == ST_OK) && (r_result.distance_mm == '0))
        else $error("status or distance without done");

    // At most one trigger line high, and only while busy
    a_one_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $onehot0(r_result.trigger_lines) &&
            ((r_result.trigger_lines == 3'b000) || r_result.busy_res))
        else $error("bad trigger lines");

    // An accepted beat always produces a result next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_valid)
        else $error("accepted beat lost");

    // A stalled result blocks new input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_m_tready |-> !o_s_tready)
        else $error("input taken over a stalled result");

endmodule

/* src/eru_regs.sv */
// Configuration registers of the echo ranger behind an APB-style port.
// Depends on eru_pkg.
module eru_regs
    import eru_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_clocks    <= TRIG_RST;
            r_cfg.echo_wait_limit   <= WAIT_RST;
            r_cfg.late_start_clocks <= LATE_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_TRIG: r_cfg.trigger_clocks    <= pwdata[TRIG_W-1:0];
                REG_WAIT: r_cfg.echo_wait_limit   <= pwdata[WAIT_W-1:0];
                REG_LATE: r_cfg.late_start_clocks <= pwdata[LATE_W-1:0];
                default:  ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_TRIG: prdata = {{(32-TRIG_W){1'b0}}, r_cfg.trigger_clocks};
            REG_WAIT: prdata = {{(32-WAIT_W){1'b0}}, r_cfg.echo_wait_limit};
            REG_LATE: prdata = {{(32-LATE_W){1'b0}}, r_cfg.late_start_clocks};
            default:  prdata = 32'd0;
        endcase
    end

endmodule

/* src/eru_width_cnt.sv */
// Echo width counter: counts echo-high clocks and keeps the distance in
// millimeters up to date step by step, so no divider is needed at the end.
// Depends on eru_pkg.
module eru_width_cnt
    import eru_pkg::*;
#(
    parameter int CLOCKS_PER_US = CLOCKS_PER_US_DEF,
    parameter int WIDTH_BITS    = WIDTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_cnt_ctl          i_ctl,
    output logic [DIST_W-1:0] o_mm
);

    localparam int SUB_W = (CLOCKS_PER_US > 1) ? $clog2(CLOCKS_PER_US) : 1;
    localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(CLOCKS_PER_US - 1);

    logic [WIDTH_BITS-1:0] r_cnt, n_cnt, w_cnt_b;
    logic [SUB_W-1:0]      r_sub, n_sub, w_sub_b;
    logic [REM_W-1:0]      r_rem, n_rem, w_rem_b;
    logic [DIST_W-1:0]     r_mm,  n_mm,  w_mm_b;
    logic [REM_W:0]        w_rem_sum;
    logic                  w_base_zero;

    assign w_base_zero = i_ctl.clear || i_ctl.load_one;
    assign w_cnt_b = w_base_zero ? '0 : r_cnt;
    assign w_sub_b = w_base_zero ? '0 : r_sub;
    assign w_rem_b = w_base_zero ? '0 : r_rem;
    assign w_mm_b  = w_base_zero ? '0 : r_mm;
    assign w_rem_sum = {1'b0, w_rem_b} + MM_NUM;

    // Advance clocks, microseconds and the distance remainder
    always_comb begin
        n_cnt = w_cnt_b;
        n_sub = w_sub_b;
        n_rem = w_rem_b;
        n_mm  = w_mm_b;
        if ((i_ctl.tick || i_ctl.load_one) && (w_cnt_b != {WIDTH_BITS{1'b1}})) begin
            n_cnt = w_cnt_b + 1'b1;
            if (w_sub_b == SUB_LAST) begin
                n_sub = '0;
                if (w_rem_sum >= MM_DEN) begin
                    n_rem = REM_W'(w_rem_sum - MM_DEN);
                    if (w_mm_b != DIST_MAX) begin
                        n_mm = w_mm_b + 1'b1;
                    end
                end else begin
                    n_rem = w_rem_sum[REM_W-1:0];
                end
            end else begin
                n_sub = w_sub_b + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sub <= '0;
            r_rem <= '0;
            r_mm  <= '0;
        end else if (i_en) begin
            r_cnt <= n_cnt;
            r_sub <= n_sub;
            r_rem <= n_rem;
            r_mm  <= n_mm;
        end
    end

    assign o_mm = r_mm;

endmodule

/* src/eru_ctrl.sv */
// Ranging sequencer: trigger pulse, echo wait with timeout, late-start skip
// and echo measurement; forms the result of each tick. Depends on eru_pkg.
module eru_ctrl
    import eru_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_cfg              i_cfg,
    input  logic              i_start_req,
    input  logic [1:0]        i_channel,
    input  logic [2:0]        i_echo_lines,
    input  logic [DIST_W-1:0] i_mm,
    output t_cnt_ctl          o_cnt_ctl,
    output t_result           o_result
);

    logic [2:0]      r_phase, n_phase;
    logic [1:0]      r_chan,  n_chan;
    logic [PC_W-1:0] r_pc,    n_pc;
    logic [PC_W-1:0] w_pc_inc;
    logic [PC_W-1:0] w_trig_len, w_wait_len, w_late;
    logic [3:0]      w_echo_ext;
    logic            w_echo_hi;

    assign w_echo_ext = {1'b0, i_echo_lines};
    assign w_echo_hi  = w_echo_ext[r_chan];
    assign w_pc_inc   = r_pc + 1'b1;
    assign w_late     = PC_W'(i_cfg.late_start_clocks);
    assign w_trig_len = (i_cfg.trigger_clocks == '0) ? PC_W'(1)
                                                     : PC_W'(i_cfg.trigger_clocks);
    assign w_wait_len = (i_cfg.echo_wait_limit == '0) ? PC_W'(1)
                                                      : i_cfg.echo_wait_limit;

    // Step the phase for this tick
    always_comb begin
        n_phase = r_phase;
        n_chan  = r_chan;
        n_pc    = r_pc;
        o_cnt_ctl = '0;
        o_result.done_res    = 1'b0;
        o_result.status      = ST_OK;
        o_result.distance_mm = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    if (i_channel == CH_INVALID) begin
                        o_result.done_res = 1'b1;
                        o_result.status   = ST_BADCH;
                    end else begin
                        n_chan  = i_channel;
                        n_phase = PH_TRIG;
                        n_pc    = PC_W'(1);
                    end
                end
            end
            PH_TRIG: begin
                if (r_pc >= w_trig_len) begin
                    n_phase = PH_WAIT;
                    n_pc    = '0;
                end else begin
                    n_pc = w_pc_inc;
                end
            end
            PH_WAIT: begin
                if (w_echo_hi) begin
                    if (r_chan == 2'd0 || w_late == '0) begin
                        n_phase = PH_MEAS;
                        o_cnt_ctl.load_one = 1'b1;
                    end else begin
                        n_pc = PC_W'(1);
                        if (w_late == PC_W'(1)) begin
                            n_phase = PH_MEAS;
                            o_cnt_ctl.clear = 1'b1;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end else begin
                    n_pc = w_pc_inc;
                    if (w_pc_inc >= w_wait_len) begin
                        o_result.done_res = 1'b1;
                        o_result.status   = ST_TIMEOUT;
                        n_phase = PH_IDLE;
                        n_pc    = '0;
                    end
                end
            end
            PH_SKIP: begin
                n_pc = w_pc_inc;
                if (w_pc_inc >= w_late) begin
                    n_phase = PH_MEAS;
                    o_cnt_ctl.clear = 1'b1;
                end
            end
            PH_MEAS: begin
                if (w_echo_hi) begin
                    o_cnt_ctl.tick = 1'b1;
                end else begin
                    o_result.done_res    = 1'b1;
                    o_result.distance_mm = i_mm;
                    n_phase = PH_IDLE;
                    n_pc    = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_pc    = '0;
            end
        endcase
        o_result.trigger_lines = (n_phase == PH_TRIG) ? (3'b001 << n_chan) : 3'b000;
        o_result.busy_res      = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_chan  <= 2'd0;
            r_pc    <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_chan  <= n_chan;
            r_pc    <= n_pc;
        end
    end

endmodule
